FILE: sv/sequential_label_remap_defines.svh
// Assertion macros used by the datapath RTL.
`ifndef SEQUENTIAL_LABEL_REMAP_DEFINES_SVH
`define SEQUENTIAL_LABEL_REMAP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// check prop on every clock edge outside reset
`define SRL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("sequential_label_remap: assertion failed");

// check prop on every clock edge, reset included
`define SRL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sequential_label_remap: assertion failed");

`else

`define SRL_ASSERT(lbl, clk, rstn, prop)
`define SRL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: sv/srl_pkg.sv
`default_nettype none

package srl_pkg;

	localparam int LABEL_W = 12;
	localparam int DATA_W  = 16;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr;      // clear one table entry, advance sweep
		logic rd;       // capture input label, read its entry
		logic resolve;  // decide result, load output, write entry if label is new
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done; // last entry is being cleared
		logic out_free; // output register can take a word this cycle
	} sts_t;

endpackage

`default_nettype wire

FILE: sv/srl_ctrl.sv
`default_nettype none

module srl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire srl_pkg::sts_t  sts,
	output srl_pkg::cmd_t       cmd
);

	srl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			srl_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = srl_pkg::ST_IDLE;
				end
			end
			srl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd  = 1'b1;
					state_d = srl_pkg::ST_LOOKUP;
				end
			end
			srl_pkg::ST_LOOKUP: begin
				// hold until the output register has room
				if (sts.out_free) begin
					cmd.resolve = 1'b1;
					state_d     = srl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = srl_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/srl_dp.sv
`default_nettype none
`include "sequential_label_remap_defines.svh"

module srl_dp #(
	parameter int LABEL_BITS = 12
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [srl_pkg::LABEL_W-1:0] in_label,
	input  wire srl_pkg::cmd_t               cmd,
	output srl_pkg::sts_t                    sts,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [srl_pkg::LABEL_W-1:0]      out_label
);

	localparam int DEPTH = 1 << LABEL_BITS;
	localparam int EXT_W = (LABEL_BITS > srl_pkg::LABEL_W) ? LABEL_BITS : srl_pkg::LABEL_W;

	// entry word: valid mark on top, new label below
	logic [LABEL_BITS:0]   mem [DEPTH];
	logic [LABEL_BITS:0]   rd_q;
	logic [LABEL_BITS-1:0] clr_q;
	logic [LABEL_BITS-1:0] key_q;
	logic [LABEL_BITS-1:0] next_q;
	logic [LABEL_BITS-1:0] new_lab;
	logic [LABEL_BITS-1:0] res;
	logic [LABEL_BITS-1:0] key_d;
	logic [EXT_W-1:0]      in_ext;
	logic [EXT_W-1:0]      res_ext;
	logic                  hit;
	logic                  bg;
	logic                  wr_en;
	logic                  out_vld_q;
	logic [srl_pkg::LABEL_W-1:0] out_q;

	// drop input bits above LABEL_BITS
	assign in_ext = EXT_W'(in_label);
	assign key_d  = in_ext[LABEL_BITS-1:0];

	assign hit     = rd_q[LABEL_BITS];
	assign bg      = (key_q == '0);
	assign new_lab = next_q + 1'b1;
	assign wr_en   = cmd.resolve && !bg && !hit;

	always_comb begin
		if (bg) begin
			res = '0;
		end else if (hit) begin
			res = rd_q[LABEL_BITS-1:0];
		end else begin
			res = new_lab;
		end
	end

	assign res_ext = EXT_W'(res);

	assign sts.clr_done = &clr_q;
	assign sts.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem[clr_q] <= '0;
		end else if (wr_en) begin
			mem[key_q] <= {1'b1, new_lab};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q  <= mem[key_d];
			key_q <= key_d;
		end
		if (cmd.resolve) begin
			out_q <= res_ext[srl_pkg::LABEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			next_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (wr_en) begin
				next_q <= new_lab;
			end
			if (cmd.resolve) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_label = out_q;

	`SRL_ASSERT(a_cnt_step, clk, arst_n, $changed(next_q) |-> next_q == $past(new_lab))
	`SRL_ASSERT(a_no_overrun, clk, arst_n, cmd.resolve |-> (!out_vld_q || out_ready))
	`SRL_ASSERT_ALWAYS(a_cmd_excl, clk, !(cmd.clr && (cmd.rd || cmd.resolve)))
	`SRL_ASSERT(a_out_hold, clk, arst_n, out_vld_q && !out_ready |=> out_vld_q && $stable(out_q))

endmodule

`default_nettype wire

FILE: sv/sequential_label_remap.sv
// Renumbers a scanned label image: label 0 passes as 0, and each nonzero label
// is mapped to 1, 2, 3, ... in order of first appearance. For each word, the
// accept cycle reads the label's table entry; the lookup state, once the output
// register has room, decides the new label and writes the entry for a new label.
// A new word is accepted only after the previous one is decided. A result waits
// in an output register, so the next word is taken while it is pending. After
// reset the table is cleared one entry per cycle, all 2^LABEL_BITS entries (4096
// by default), with s_tready low; a reset starts a new image.
`default_nettype none

module sequential_label_remap #(
	parameter int LABEL_BITS = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [srl_pkg::DATA_W-1:0] s_tdata,  // [11:0] in_label
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [srl_pkg::DATA_W-1:0]      m_tdata   // [11:0] out_label
);

	srl_pkg::cmd_t cmd;
	srl_pkg::sts_t sts;
	logic [srl_pkg::LABEL_W-1:0] out_label;

	srl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srl_dp #(
		.LABEL_BITS (LABEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_label  (s_tdata[srl_pkg::LABEL_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_label (out_label)
	);

	assign m_tdata = srl_pkg::DATA_W'(out_label);

endmodule

`default_nettype wire

FILE: test/label_remap_checker.sv
`timescale 1ns / 100ps

module label_remap_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [srl_pkg::DATA_W-1:0] s_tdata,  // [11:0] in_label
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [srl_pkg::DATA_W-1:0] m_tdata,  // [11:0] out_label
	output int                         errors,
	output int                         pending
);

	localparam int DEPTH = 1 << srl_pkg::LABEL_W;

	bit                          label_seen [0:DEPTH-1];
	logic [srl_pkg::LABEL_W-1:0] mapped_label [0:DEPTH-1];
	logic [srl_pkg::LABEL_W-1:0] issued_count;
	logic [srl_pkg::LABEL_W-1:0] expected_labels[$];

	initial begin
		for (int i = 0; i < DEPTH; i++) begin
			label_seen[i]   = 1'b0;
			mapped_label[i] = '0;
		end
		issued_count = '0;
		errors       = 0;
		pending      = 0;
	end

	// Renumber one pixel and update the mapping, as the block does.
	function automatic logic [srl_pkg::LABEL_W-1:0] renumber(
		input logic [srl_pkg::LABEL_W-1:0] lbl
	);
		if (lbl == '0)
			return '0;
		if (label_seen[lbl])
			return mapped_label[lbl];
		issued_count      = issued_count + 1'b1;
		mapped_label[lbl] = issued_count;
		label_seen[lbl]   = 1'b1;
		return issued_count;
	endfunction

	always @(posedge clk) begin
		logic [srl_pkg::LABEL_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_labels.size() == 0) begin
					$error("unexpected word on output: out_label %0d",
						m_tdata[srl_pkg::LABEL_W-1:0]);
					errors <= errors + 1;
				end else begin
					want = expected_labels.pop_front();
					if (m_tdata[srl_pkg::LABEL_W-1:0] !== want) begin
						$error("out_label mismatch: expected %0d, got %0d",
							want, m_tdata[srl_pkg::LABEL_W-1:0]);
						errors <= errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_labels.push_back(renumber(s_tdata[srl_pkg::LABEL_W-1:0]));
			pending <= expected_labels.size();
		end
	end

endmodule

FILE: test/sequential_label_remap_tb.sv
`timescale 1ns / 100ps

module sequential_label_remap_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_WORDS    = 135;
	localparam int POOL_SIZE      = 24;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [srl_pkg::DATA_W-1:0] s_tdata = '0;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [srl_pkg::DATA_W-1:0] m_tdata;

	int errors;
	int pending;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	logic [srl_pkg::LABEL_W-1:0] label_pool[POOL_SIZE];
	logic [srl_pkg::LABEL_W-1:0] prev_label = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sequential_label_remap DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	label_remap_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Present one pixel, with random idle cycles ahead of it, and hold until taken.
	task automatic send_pixel(input logic [srl_pkg::LABEL_W-1:0] lbl);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(srl_pkg::DATA_W-srl_pkg::LABEL_W){1'b0}}, lbl};
		prev_label = lbl;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait for every outstanding word to come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Labels from a small pool, plus background, repeats of the last one and fresh ones.
	function automatic logic [srl_pkg::LABEL_W-1:0] pick_label();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return '0;
		if (r < 60)
			return label_pool[$urandom_range(POOL_SIZE-1)];
		if (r < 72)
			return prev_label;
		return srl_pkg::LABEL_W'($urandom_range((1 << srl_pkg::LABEL_W) - 1, 1));
	endfunction

	initial begin
		logic [srl_pkg::LABEL_W-1:0] directed[$];
		int idle_set[4];
		int stall_set[4];

		directed = '{12'd0, 12'hFFF, 12'hFFF, 12'd1, 12'd0, 12'h800, 12'h800, 12'd1,
			12'hAAA, 12'h555, 12'hFFF, 12'd2, 12'd3, 12'd4, 12'd5, 12'd2, 12'd0,
			12'h7FF, 12'hAAA, 12'd0, 12'd6};
		idle_set  = '{0, 46, 0, 24};
		stall_set = '{0, 0, 46, 24};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_pixel(directed[i]);
		drain();

		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_set[p];
			stall_pct = stall_set[p];
			for (int i = 0; i < POOL_SIZE; i++)
				label_pool[i] = srl_pkg::LABEL_W'($urandom_range((1 << srl_pkg::LABEL_W) - 1, 1));
			for (int n = 0; n < PHASE_WORDS; n++)
				send_pixel(pick_label());
			drain();
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/srl_pkg.sv
sv/srl_ctrl.sv
sv/srl_dp.sv
sv/sequential_label_remap.sv
test/label_remap_checker.sv
test/sequential_label_remap_tb.sv
